// ===== rtl/core/dmdsc_pkg.sv =====
// Package for the dual motor drive with slew limiting and battery compensation.
// Holds register indexes, reset values and the controller/datapath link types.
// No dependencies.
`default_nettype none

package dmdsc_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CMD_W     = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DVD_W     = 30;
  localparam int unsigned FRAC_W    = 14;
  localparam int unsigned DIV_STEPS = 15;
  localparam int unsigned CNT_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_MV = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MV     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMIT  = 3'd4;

  localparam logic [DATA_W-1:0] RST_NOMINAL_MV = 16'd11095;
  localparam logic [DATA_W-1:0] RST_MIN_MV     = 16'd6000;
  localparam logic [DATA_W-1:0] RST_MAX_RATIO  = 16'd21299;
  localparam logic [DATA_W-1:0] RST_MAX_STEP   = 16'd200;
  localparam logic [DATA_W-1:0] RST_PWM_LIMIT  = 16'd10000;

  typedef struct packed {
    logic load;
    logic div_step;
    logic ratio_en;
    logic mul_en;
    logic mul_right;
    logic slew_en;
    logic slew_right;
    logic out_write;
  } cmd_t;

  typedef struct packed {
    logic uv;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dmdsc_if.sv =====
// Valid/ready channel interfaces for the motor drive input and output.
// No dependencies.
`default_nettype none

interface dmdsc_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] battery_mv;
  logic signed [15:0] target_left;
  logic signed [15:0] target_right;

  modport source (output valid, output battery_mv, output target_left,
                  output target_right, input ready);
  modport sink (input valid, input battery_mv, input target_left,
                input target_right, output ready);
endinterface

interface dmdsc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_duty;
  logic        left_forward;
  logic [15:0] right_duty;
  logic        right_forward;
  logic        undervoltage;

  modport source (output valid, output left_duty, output left_forward,
                  output right_duty, output right_forward, output undervoltage,
                  input ready);
  modport sink (input valid, input left_duty, input left_forward,
                input right_duty, input right_forward, input undervoltage,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dmdsc_ctrl.sv =====
// Sequencer for the motor drive: divide, cap, multiply, slew, output; undervoltage skips to output.
// Depends on dmdsc_pkg.
`default_nettype none

module dmdsc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dmdsc_pkg::sts_t sts,
  output dmdsc_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DIV,
    RATIO,
    MUL_L,
    MUL_R,
    SLEW_R,
    OUTP
  } state_t;

  state_t                         state;
  logic [dmdsc_pkg::CNT_W-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          cnt <= '0;
          if (in_valid) state <= DIV;
        end
        DIV: begin
          if (sts.uv) begin
            state <= OUTP;
          end else begin
            cnt <= cnt + 1'b1;
            if (cnt == dmdsc_pkg::CNT_W'(dmdsc_pkg::DIV_STEPS - 1)) state <= RATIO;
          end
        end
        RATIO:  state <= MUL_L;
        MUL_L:  state <= MUL_R;
        MUL_R:  state <= SLEW_R;
        SLEW_R: state <= OUTP;
        OUTP: begin
          if (sts.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      DIV:    cmd.div_step = ~sts.uv;
      RATIO:  cmd.ratio_en = 1'b1;
      MUL_L:  cmd.mul_en   = 1'b1;
      MUL_R: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_right = 1'b1;
        cmd.slew_en   = 1'b1;
      end
      SLEW_R: begin
        cmd.slew_en    = 1'b1;
        cmd.slew_right = 1'b1;
      end
      OUTP:   cmd.out_write = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/dmdsc_dp.sv =====
// Datapath: config registers, radix-4 divider, shared multiplier, slew limiter,
// command state and output register. Depends on dmdsc_pkg.
`default_nettype none

module dmdsc_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [dmdsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dmdsc_pkg::DATA_W-1:0]      cfg_data,
  input  wire logic [15:0]                       battery_mv,
  input  wire logic signed [15:0]                target_left,
  input  wire logic signed [15:0]                target_right,
  input  wire dmdsc_pkg::cmd_t                   cmd,
  output dmdsc_pkg::sts_t                        sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [15:0]                            left_duty,
  output logic                                   left_forward,
  output logic [15:0]                            right_duty,
  output logic                                   right_forward,
  output logic                                   undervoltage
);

  localparam int unsigned DW = dmdsc_pkg::DATA_W;
  localparam int unsigned CW = dmdsc_pkg::CMD_W;
  localparam int unsigned VW = dmdsc_pkg::DVD_W;
  localparam int unsigned FW = dmdsc_pkg::FRAC_W;

  logic [DW-1:0] nominal_mv, min_mv, max_ratio, max_step, pwm_limit;

  logic [DW-1:0]  batt;
  logic [DW-1:0]  mag_l, mag_r;
  logic           neg_l, neg_r;
  logic           uv;
  logic [DW-1:0]  rem;
  logic [VW-1:0]  dvd;
  logic [DW-1:0]  ratio;
  logic [2*DW-1:0] prod;
  logic signed [CW-1:0] prev_l, prev_r;

  // divider: two quotient bits per step
  logic [DW:0]   r1, r2;
  logic          q1, q2;
  logic [DW-1:0] r1s, r2s;

  // slew
  logic [CW-1:0]        p_mag;
  logic signed [CW+1:0] cur, hi, lo, slewed;
  logic signed [CW-1:0] prev_sel;
  logic                 slew_neg;

  logic [DW:0]          drv_l, drv_r;

  function automatic logic [DW:0] drive(input logic signed [CW-1:0] c,
                                        input logic [DW-1:0] limit);
    logic [CW-1:0] m;
    logic          fwd;
    begin
      fwd = ~c[CW-1];
      m   = fwd ? c : CW'(-c);
      if (m > {{(CW-DW){1'b0}}, limit}) m = {{(CW-DW){1'b0}}, limit};
      drive = {fwd, m[DW-1:0]};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_mv <= dmdsc_pkg::RST_NOMINAL_MV;
      min_mv     <= dmdsc_pkg::RST_MIN_MV;
      max_ratio  <= dmdsc_pkg::RST_MAX_RATIO;
      max_step   <= dmdsc_pkg::RST_MAX_STEP;
      pwm_limit  <= dmdsc_pkg::RST_PWM_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        dmdsc_pkg::REG_NOMINAL_MV: nominal_mv <= cfg_data;
        dmdsc_pkg::REG_MIN_MV:     min_mv     <= cfg_data;
        dmdsc_pkg::REG_MAX_RATIO:  max_ratio  <= cfg_data;
        dmdsc_pkg::REG_MAX_STEP:   max_step   <= cfg_data;
        dmdsc_pkg::REG_PWM_LIMIT:  pwm_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    r1  = {rem, dvd[VW-1]};
    q1  = (r1 >= {1'b0, batt});
    r1s = q1 ? DW'(r1 - {1'b0, batt}) : r1[DW-1:0];
    r2  = {r1s, dvd[VW-2]};
    q2  = (r2 >= {1'b0, batt});
    r2s = q2 ? DW'(r2 - {1'b0, batt}) : r2[DW-1:0];
  end

  always_comb begin
    p_mag    = prod[FW+CW-1:FW];
    slew_neg = cmd.slew_right ? neg_r : neg_l;
    prev_sel = cmd.slew_right ? prev_r : prev_l;
    cur      = slew_neg ? -$signed({2'b00, p_mag}) : $signed({2'b00, p_mag});
    hi       = $signed({{2{prev_sel[CW-1]}}, prev_sel}) + $signed({4'b0000, max_step});
    lo       = $signed({{2{prev_sel[CW-1]}}, prev_sel}) - $signed({4'b0000, max_step});
    if (cur > hi)      slewed = hi;
    else if (cur < lo) slewed = lo;
    else               slewed = cur;
    drv_l = drive(prev_l, pwm_limit);
    drv_r = drive(prev_r, pwm_limit);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      batt  <= battery_mv;
      uv    <= (battery_mv < min_mv);
      neg_l <= target_left[15];
      neg_r <= target_right[15];
      mag_l <= target_left[15] ? DW'(-target_left) : target_left;
      mag_r <= target_right[15] ? DW'(-target_right) : target_right;
      rem   <= '0;
      dvd   <= {nominal_mv, {FW{1'b0}}};
    end
    if (cmd.div_step) begin
      rem <= r2s;
      dvd <= {dvd[VW-3:0], q1, q2};
    end
    // a zero divisor yields an all-ones quotient, which the cap catches
    if (cmd.ratio_en) begin
      if (dvd[VW-1:DW] != '0 || dvd[DW-1:0] > max_ratio) ratio <= max_ratio;
      else ratio <= dvd[DW-1:0];
    end
    if (cmd.mul_en) begin
      prod <= (cmd.mul_right ? mag_r : mag_l) * ratio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_l    <= '0;
      prev_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.slew_en) begin
        if (cmd.slew_right) prev_r <= slewed[CW-1:0];
        else                prev_l <= slewed[CW-1:0];
      end
      if (cmd.out_write) begin
        out_valid <= 1'b1;
        if (uv) begin
          prev_l <= '0;
          prev_r <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      undervoltage <= uv;
      if (uv) begin
        left_duty     <= '0;
        left_forward  <= 1'b1;
        right_duty    <= '0;
        right_forward <= 1'b1;
      end else begin
        left_duty     <= drv_l[DW-1:0];
        left_forward  <= drv_l[DW];
        right_duty    <= drv_r[DW-1:0];
        right_forward <= drv_r[DW];
      end
    end
  end

  assign sts.uv       = uv;
  assign sts.out_free = ~out_valid | out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/dual_motor_drive_slew_comp.sv =====
// Dual motor drive with battery compensation and slew limiting.
// The path from input transfer to output valid runs through the 15-step radix-4 ratio
// divider, which undervoltage skips. One item at a time; an output stall holds the next
// item. The output register frees the input.
// Synchronous reset restores register defaults and clears both commands.
// Depends on dmdsc_pkg, dmdsc_if, dmdsc_ctrl, dmdsc_dp.
`default_nettype none

module dual_motor_drive_slew_comp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [dmdsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dmdsc_pkg::DATA_W-1:0]    cfg_data,
  dmdsc_in_if.sink                             cmd_in,
  dmdsc_out_if.source                          drv_out
);

  dmdsc_pkg::cmd_t cmd;
  dmdsc_pkg::sts_t sts;
  logic            in_ready;

  assign cmd_in.ready = in_ready;

  dmdsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmdsc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .battery_mv    (cmd_in.battery_mv),
    .target_left   (cmd_in.target_left),
    .target_right  (cmd_in.target_right),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (drv_out.valid),
    .out_ready     (drv_out.ready),
    .left_duty     (drv_out.left_duty),
    .left_forward  (drv_out.left_forward),
    .right_duty    (drv_out.right_duty),
    .right_forward (drv_out.right_forward),
    .undervoltage  (drv_out.undervoltage)
  );

endmodule

`default_nettype wire
